### hw/rtl/ipcb_pkg.sv
// ----------------------------------------------------------------------------
// ipcb_pkg
// shared types, field widths and codes of the interval profiling counter bank
// ----------------------------------------------------------------------------
package ipcb_pkg;

	localparam int unsigned NUM_TIMERS_DEF = 16;

	// field widths
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned TI_W     = 4;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned ENTRY_W  = 4;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned ADDR_W   = 3;

	// input item kinds
	localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_START = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_POLL  = 2'd3;

	// result kinds
	localparam logic [1:0] RES_REPORT = 2'd0;
	localparam logic [1:0] RES_HEADER = 2'd1;
	localparam logic [1:0] RES_ENTRY  = 2'd2;

	// register index (word address bit of paddr)
	localparam logic REG_PERIOD = 1'b0;

	// milliseconds per second, split as 8 * 125 for the reciprocal divide
	localparam int unsigned MS_PER_S    = 1000;
	localparam int unsigned PMS_W       = 26;
	localparam int unsigned DIV_SHIFT   = 3;
	localparam int unsigned DIV_ODD     = 125;
	localparam int unsigned RECIP_SHIFT = 30;
	localparam int unsigned RECIP_W     = 24;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(DIV_ODD));
	localparam int unsigned Y_W    = PMS_W - DIV_SHIFT;
	localparam int unsigned PROD_W = Y_W + RECIP_W;
	localparam int unsigned Q_W    = PROD_W - RECIP_SHIFT;

	// command queue between front and back
	localparam int unsigned CMD_Q_DEPTH = 4;
	localparam int unsigned CMD_Q_AW    = 2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [TI_W-1:0]   idx;
		logic [TIME_W-1:0] ts;
	} cmd_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic full;
		logic empty;
	} cmdq_ctl_t;

endpackage

### hw/rtl/ipcb_front.sv
// ----------------------------------------------------------------------------
// ipcb_front
// accepts items, keeps the millisecond clock and queues timed commands
// ----------------------------------------------------------------------------
module ipcb_front #(
	parameter int unsigned NUM_TIMERS = ipcb_pkg::NUM_TIMERS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [ipcb_pkg::KIND_W-1:0]  kind,
	input  logic [ipcb_pkg::TI_W-1:0]    timer_index,
	input  logic                         enabled,
	input  logic                         q_full,
	output logic                         q_push,
	output ipcb_pkg::cmd_t               q_data
);
	import ipcb_pkg::*;

	logic [TIME_W-1:0] now_ms_q;
	logic              push_fire;
	logic              in_range;
	logic              is_timer_op;

	assign push_fire   = push & ~q_full;
	assign in_range    = 32'(timer_index) < 32'(NUM_TIMERS);
	assign is_timer_op = (kind == KIND_START) || (kind == KIND_STOP);
	assign full        = q_full;

	// ticks stay here, disabled or out of range timer ops are dropped
	assign q_push = push_fire &
		((kind == KIND_POLL) || (is_timer_op && enabled && in_range));

	assign q_data.kind = kind;
	assign q_data.idx  = timer_index;
	assign q_data.ts   = now_ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_ms_q <= '0;
		end else if (push_fire && (kind == KIND_TICK)) begin
			now_ms_q <= now_ms_q + TIME_W'(1);
		end
	end

endmodule

### hw/rtl/ipcb_queue.sv
// ----------------------------------------------------------------------------
// ipcb_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module ipcb_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ipcb_pkg::cmd_t       wr_data,
	input  logic                 pop,
	output ipcb_pkg::cmd_t       rd_data,
	output ipcb_pkg::cmdq_ctl_t  ctl
);
	import ipcb_pkg::*;

	cmd_t                slot_q [CMD_Q_DEPTH];
	logic [CMD_Q_AW-1:0] wr_ptr_q;
	logic [CMD_Q_AW-1:0] rd_ptr_q;
	logic [CMD_Q_AW:0]   cnt_q;
	logic                do_push;
	logic                do_pop;

	assign ctl.full  = cnt_q == (CMD_Q_AW+1)'(CMD_Q_DEPTH);
	assign ctl.empty = cnt_q == '0;
	assign do_push   = push & ~ctl.full;
	assign do_pop    = pop & ~ctl.empty;
	assign ctl.push  = do_push;
	assign ctl.pop   = do_pop;
	assign rd_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + CMD_Q_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + CMD_Q_AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + (CMD_Q_AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (CMD_Q_AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hw/rtl/ipcb_back.sv
// ----------------------------------------------------------------------------
// ipcb_back
// timer bank: carries out start, stop and poll commands, drives the results
// ----------------------------------------------------------------------------
module ipcb_back #(
	parameter int unsigned NUM_TIMERS = ipcb_pkg::NUM_TIMERS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ipcb_pkg::PERIOD_W-1:0] period,
	input  ipcb_pkg::cmd_t                q_data,
	input  logic                          q_empty,
	output logic                          q_pop,
	input  logic                          pop,
	output logic                          empty,
	output logic [1:0]                    result_kind,
	output logic [ipcb_pkg::PERIOD_W-1:0] seconds_left,
	output logic [ipcb_pkg::TIME_W-1:0]   elapsed_ms,
	output logic [ipcb_pkg::ENTRY_W-1:0]  entry_index,
	output logic [ipcb_pkg::TIME_W-1:0]   total_ms,
	output logic [ipcb_pkg::TIME_W-1:0]   event_count,
	output logic                          last
);
	import ipcb_pkg::*;

	localparam int unsigned AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(NUM_TIMERS - 1);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_STOP    = 3'd1;
	localparam logic [2:0] ST_POLL    = 3'd2;
	localparam logic [2:0] ST_DIV1    = 3'd3;
	localparam logic [2:0] ST_DIV2    = 3'd4;
	localparam logic [2:0] ST_DIV3    = 3'd5;
	localparam logic [2:0] ST_ENT_RD  = 3'd6;
	localparam logic [2:0] ST_ENT_OUT = 3'd7;

	logic [2:0]          state_q, state_d;
	cmd_t                cmd_q;
	logic [AW-1:0]       cmd_addr_q;
	logic [AW-1:0]       ent_q, ent_d;
	logic [AW-1:0]       rd_idx_q;
	logic [AW-1:0]       head_addr, rd_addr;
	logic [31:0]         head_idx32, ent_idx32;

	logic [TIME_W-1:0]   beg_mem_q [NUM_TIMERS];
	logic [TIME_W-1:0]   tot_mem_q [NUM_TIMERS];
	logic [TIME_W-1:0]   cnt_mem_q [NUM_TIMERS];
	logic [TIME_W-1:0]   beg_rd_q, tot_rd_q, cnt_rd_q;
	logic [TIME_W-1:0]   beg_rd, tot_rd, cnt_rd;
	logic [NUM_TIMERS-1:0] beg_vld_q, acc_vld_q;

	logic                ever_q;
	logic [TIME_W-1:0]   last_rep_q;
	logic [PMS_W-1:0]    period_ms_q;
	logic [Y_W-1:0]      y_q;
	logic [PROD_W-1:0]   prod_q;
	logic [Q_W-1:0]      q_q, q_est, q_fix;
	logic [Y_W-1:0]      qm_q, rem;

	logic                enabled;
	logic [TIME_W-1:0]   elapsed;
	logic [TIME_W-1:0]   tot_new;
	logic                out_vld_q, out_fire, can_emit;

	logic                emit, beg_we, acc_we, clr_ent, rep_upd;
	logic [1:0]          e_kind;
	logic [PERIOD_W-1:0] e_secs;
	logic [TIME_W-1:0]   e_ems, e_tot, e_cnt;
	logic [ENTRY_W-1:0]  e_idx;
	logic                e_last;

	assign enabled    = period != '0;
	assign head_idx32 = 32'(q_data.idx);
	assign head_addr  = head_idx32[AW-1:0];
	assign ent_idx32  = 32'(ent_q);
	assign rd_addr    = (state_q == ST_IDLE) ? head_addr : ent_q;
	assign q_pop      = (state_q == ST_IDLE) & ~q_empty;

	// entries never written read as zero
	assign beg_rd = beg_vld_q[rd_idx_q] ? beg_rd_q : '0;
	assign tot_rd = acc_vld_q[rd_idx_q] ? tot_rd_q : '0;
	assign cnt_rd = acc_vld_q[rd_idx_q] ? cnt_rd_q : '0;

	assign tot_new = tot_rd + (cmd_q.ts - beg_rd);
	assign elapsed = cmd_q.ts - last_rep_q;

	// floor(elapsed / 1000) = floor((elapsed >> 3) / 125), reciprocal plus one fix-up
	assign q_est = prod_q[RECIP_SHIFT +: Q_W];
	assign rem   = y_q - qm_q;
	assign q_fix = q_q + Q_W'(rem >= Y_W'(DIV_ODD));

	assign out_fire = pop & out_vld_q;
	assign can_emit = ~out_vld_q | out_fire;

	always_comb begin
		state_d = state_q;
		ent_d   = ent_q;
		emit    = 1'b0;
		beg_we  = 1'b0;
		acc_we  = 1'b0;
		clr_ent = 1'b0;
		rep_upd = 1'b0;
		e_kind  = RES_REPORT;
		e_secs  = '0;
		e_ems   = '0;
		e_idx   = '0;
		e_tot   = '0;
		e_cnt   = '0;
		e_last  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					case (q_data.kind)
						KIND_START: beg_we  = 1'b1;
						KIND_STOP:  state_d = ST_STOP;
						KIND_POLL:  state_d = ST_POLL;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_STOP: begin
				acc_we  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_POLL: begin
				if (!enabled) begin
					if (can_emit) begin
						emit    = 1'b1;
						e_last  = 1'b1;
						state_d = ST_IDLE;
					end
				end else if (elapsed < TIME_W'(period_ms_q)) begin
					state_d = ST_DIV1;
				end else if (can_emit) begin
					emit    = 1'b1;
					e_kind  = RES_HEADER;
					e_ems   = elapsed;
					e_last  = ~ever_q;
					rep_upd = 1'b1;
					ent_d   = '0;
					state_d = ever_q ? ST_ENT_RD : ST_IDLE;
				end
			end
			ST_DIV1: state_d = ST_DIV2;
			ST_DIV2: state_d = ST_DIV3;
			ST_DIV3: begin
				if (can_emit) begin
					emit    = 1'b1;
					e_secs  = period - q_fix[PERIOD_W-1:0];
					e_last  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_ENT_RD: state_d = ST_ENT_OUT;
			ST_ENT_OUT: begin
				if (can_emit) begin
					emit    = 1'b1;
					e_kind  = RES_ENTRY;
					e_idx   = ent_idx32[ENTRY_W-1:0];
					e_tot   = tot_rd;
					e_cnt   = cnt_rd;
					e_last  = ent_q == LAST_IDX;
					clr_ent = 1'b1;
					if (ent_q == LAST_IDX) begin
						state_d = ST_IDLE;
					end else begin
						ent_d   = ent_q + AW'(1);
						state_d = ST_ENT_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// timer memories, one write and one registered read each
	always_ff @(posedge clk) begin
		if (beg_we) begin
			beg_mem_q[head_addr] <= q_data.ts;
		end
		if (acc_we) begin
			tot_mem_q[cmd_addr_q] <= tot_new;
			cnt_mem_q[cmd_addr_q] <= cnt_rd + TIME_W'(1);
		end
		beg_rd_q <= beg_mem_q[rd_addr];
		tot_rd_q <= tot_mem_q[rd_addr];
		cnt_rd_q <= cnt_mem_q[rd_addr];
		rd_idx_q <= rd_addr;
	end

	// command and divider datapath
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q      <= q_data;
			cmd_addr_q <= head_addr;
		end
		y_q    <= elapsed[DIV_SHIFT +: Y_W];
		prod_q <= PROD_W'(y_q) * PROD_W'(RECIP);
		q_q    <= q_est;
		qm_q   <= Y_W'(q_est) * Y_W'(DIV_ODD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ent_q       <= '0;
			beg_vld_q   <= '0;
			acc_vld_q   <= '0;
			ever_q      <= 1'b0;
			last_rep_q  <= '0;
			period_ms_q <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			ent_q       <= ent_d;
			period_ms_q <= PMS_W'(period * PMS_W'(MS_PER_S));
			if (beg_we) begin
				beg_vld_q[head_addr] <= 1'b1;
				ever_q               <= 1'b1;
			end
			if (acc_we) begin
				acc_vld_q[cmd_addr_q] <= 1'b1;
			end
			if (clr_ent) begin
				acc_vld_q[ent_q] <= 1'b0;
			end
			if (rep_upd) begin
				last_rep_q <= cmd_q.ts;
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (out_fire) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_kind  <= e_kind;
			seconds_left <= e_secs;
			elapsed_ms   <= e_ems;
			entry_index  <= e_idx;
			total_ms     <= e_tot;
			event_count  <= e_cnt;
			last         <= e_last;
		end
	end

	assign empty = ~out_vld_q;

endmodule

### hw/rtl/interval_profiling_counter_bank_unit.sv
// throughput: a tick is taken every cycle while the command queue has room; it yields no result
// start and stop pass the queue; start writes its start time as it leaves, stop reads, then writes back
// a report poll steps through compare, reciprocal multiply, fix-up and result
// a summary poll emits its header, then each entry in turn after a registered read
// reset: clock, totals, counts and start times read as zero at once, period 0 disables the bank
// ----------------------------------------------------------------------------
// interval_profiling_counter_bank_unit
// bank of interval timers on a tick-driven millisecond clock with periodic summaries
// ----------------------------------------------------------------------------
module interval_profiling_counter_bank_unit #(
	parameter int unsigned NUM_TIMERS = ipcb_pkg::NUM_TIMERS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// item side
	input  logic                          push,
	output logic                          full,
	input  logic [ipcb_pkg::KIND_W-1:0]   kind,
	input  logic [ipcb_pkg::TI_W-1:0]     timer_index,
	// result side
	output logic                          empty,
	input  logic                          pop,
	output logic [1:0]                    result_kind,
	output logic [ipcb_pkg::PERIOD_W-1:0] seconds_left,
	output logic [ipcb_pkg::TIME_W-1:0]   elapsed_ms,
	output logic [ipcb_pkg::ENTRY_W-1:0]  entry_index,
	output logic [ipcb_pkg::TIME_W-1:0]   total_ms,
	output logic [ipcb_pkg::TIME_W-1:0]   event_count,
	output logic                          last,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ipcb_pkg::ADDR_W-1:0]   paddr,
	input  logic [ipcb_pkg::DATA_W-1:0]   pwdata,
	output logic [ipcb_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import ipcb_pkg::*;

	logic [PERIOD_W-1:0] period_q;
	logic                cfg_wr;
	logic                reg_sel;
	cmd_t                f_cmd;
	cmd_t                b_cmd;
	logic                f_push;
	logic                b_pop;
	cmdq_ctl_t           q_ctl;

	// register file: the reporting period is the only register, at word 0
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign prdata  = (reg_sel == REG_PERIOD) ? DATA_W'(period_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
		end else if (cfg_wr && (reg_sel == REG_PERIOD)) begin
			period_q <= pwdata[PERIOD_W-1:0];
		end
	end

	// front: owns the millisecond clock, stamps and filters commands
	ipcb_front #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.kind        (kind),
		.timer_index (timer_index),
		.enabled     (period_q != '0),
		.q_full      (q_ctl.full),
		.q_push      (f_push),
		.q_data      (f_cmd)
	);

	// decouples ticks from the slower work of the back
	ipcb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (f_push),
		.wr_data (f_cmd),
		.pop     (b_pop),
		.rd_data (b_cmd),
		.ctl     (q_ctl)
	);

	// back: timer memories, period check and the result register
	ipcb_back #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.period       (period_q),
		.q_data       (b_cmd),
		.q_empty      (q_ctl.empty),
		.q_pop        (b_pop),
		.pop          (pop),
		.empty        (empty),
		.result_kind  (result_kind),
		.seconds_left (seconds_left),
		.elapsed_ms   (elapsed_ms),
		.entry_index  (entry_index),
		.total_ms     (total_ms),
		.event_count  (event_count),
		.last         (last)
	);

endmodule

### hw/rtl/ipcb_checker.sv
// ----------------------------------------------------------------------------
// ipcb_checker
// port-level checks of the result side, bound to the top level
// ----------------------------------------------------------------------------
module ipcb_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          empty,
	input logic                          pop,
	input logic [1:0]                    result_kind,
	input logic [ipcb_pkg::PERIOD_W-1:0] seconds_left,
	input logic [ipcb_pkg::TIME_W-1:0]   elapsed_ms,
	input logic [ipcb_pkg::ENTRY_W-1:0]  entry_index,
	input logic [ipcb_pkg::TIME_W-1:0]   total_ms,
	input logic [ipcb_pkg::TIME_W-1:0]   event_count,
	input logic                          last
);
	import ipcb_pkg::*;

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("waiting result dropped without a transfer");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(result_kind) && $stable(last) &&
			$stable(total_ms) && $stable(elapsed_ms))
		else $error("waiting result changed before its transfer");

	a_report_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result_kind == RES_REPORT |-> last)
		else $error("seconds report not marked last");

	a_summary_no_secs: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result_kind != RES_REPORT |-> seconds_left == '0)
		else $error("summary result carries seconds left");

	a_header_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result_kind == RES_HEADER |->
			entry_index == '0 && total_ms == '0 && event_count == '0)
		else $error("summary header carries entry fields");

endmodule

bind interval_profiling_counter_bank_unit ipcb_checker u_ipcb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.result_kind  (result_kind),
	.seconds_left (seconds_left),
	.elapsed_ms   (elapsed_ms),
	.entry_index  (entry_index),
	.total_ms     (total_ms),
	.event_count  (event_count),
	.last         (last)
);

### sim/tb_interval_profiling_counter_bank_unit.sv
// ----------------------------------------------------------------------------
// tb_interval_profiling_counter_bank_unit
// self-checking bench for the interval profiling counter bank: a directed
// table of items and period writes, then random start/stop/tick/poll traffic
// over several report periods, every result checked against a local model
// ----------------------------------------------------------------------------
module tb_interval_profiling_counter_bank_unit;

	import ipcb_pkg::*;

	localparam int unsigned NT           = NUM_TIMERS_DEF;
	localparam int          SETTLE_CYC   = 64;
	localparam int          CYCLE_LIMIT  = 1500000;
	localparam int          PHASE_ITEMS  = 30;
	localparam int          NUM_PHASES   = 6;

	// one result transfer, field by field
	typedef struct packed {
		logic [1:0]          rkind;
		logic [PERIOD_W-1:0] secs;
		logic [TIME_W-1:0]   ems;
		logic [ENTRY_W-1:0]  eidx;
		logic [TIME_W-1:0]   tot;
		logic [TIME_W-1:0]   cnt;
		logic                fin;
	} result_t;

	typedef enum logic [0:0] {
		ROW_ITEM,
		ROW_CFG
	} row_op_t;

	// one row of the directed table: an item repeated reps times, or a period write
	typedef struct packed {
		row_op_t             op;
		logic [KIND_W-1:0]   kind;
		logic [TI_W-1:0]     idx;
		logic [15:0]         reps;
		logic [PERIOD_W-1:0] cfg;
		logic                typed;
		result_t             want;
	} row_t;

	localparam result_t NO_RES      = '0;
	localparam result_t REPORT_OFF  = '{RES_REPORT, 16'd0, 32'd0, 4'd0, 32'd0, 32'd0, 1'b1};
	localparam result_t REPORT_1S   = '{RES_REPORT, 16'd1, 32'd0, 4'd0, 32'd0, 32'd0, 1'b1};
	localparam result_t REPORT_MAX  = '{RES_REPORT, 16'hFFFF, 32'd0, 4'd0, 32'd0, 32'd0, 1'b1};
	localparam result_t HEADER_ONLY = '{RES_HEADER, 16'd0, 32'd1000, 4'd0, 32'd0, 32'd0, 1'b1};

	localparam row_t DIRECTED [26] = '{
		'{ROW_ITEM, KIND_POLL,  4'd0,  16'd1,    16'd0,     1'b1, REPORT_OFF},
		'{ROW_ITEM, KIND_START, 4'd0,  16'd1,    16'd0,     1'b0, NO_RES},
		'{ROW_ITEM, KIND_STOP,  4'd15, 16'd1,    16'd0,     1'b0, NO_RES},
		'{ROW_ITEM, KIND_TICK,  4'd0,  16'd1,    16'd0,     1'b0, NO_RES},
		'{ROW_CFG,  KIND_TICK,  4'd0,  16'd0,    16'd1,     1'b0, NO_RES},
		'{ROW_ITEM, KIND_POLL,  4'd0,  16'd1,    16'd0,     1'b1, REPORT_1S},
		'{ROW_ITEM, KIND_STOP,  4'd3,  16'd1,    16'd0,     1'b0, NO_RES},
		'{ROW_ITEM, KIND_TICK,  4'd9,  16'd999,  16'd0,     1'b0, NO_RES},
		'{ROW_ITEM, KIND_POLL,  4'd0,  16'd1,    16'd0,     1'b1, HEADER_ONLY},
		'{ROW_ITEM, KIND_START, 4'd15, 16'd1,    16'd0,     1'b0, NO_RES},
		'{ROW_ITEM, KIND_START, 4'd0,  16'd1,    16'd0,     1'b0, NO_RES},
		'{ROW_ITEM, KIND_TICK,  4'd6,  16'd700,  16'd0,     1'b0, NO_RES},
		'{ROW_ITEM, KIND_STOP,  4'd0,  16'd1,    16'd0,     1'b0, NO_RES},
		'{ROW_ITEM, KIND_STOP,  4'd15, 16'd1,    16'd0,     1'b0, NO_RES},
		'{ROW_ITEM, KIND_STOP,  4'd3,  16'd1,    16'd0,     1'b0, NO_RES},
		'{ROW_ITEM, KIND_TICK,  4'd15, 16'd300,  16'd0,     1'b0, NO_RES},
		'{ROW_ITEM, KIND_POLL,  4'd15, 16'd1,    16'd0,     1'b0, NO_RES},
		'{ROW_ITEM, KIND_POLL,  4'd0,  16'd1,    16'd0,     1'b0, NO_RES},
		'{ROW_CFG,  KIND_TICK,  4'd0,  16'd0,    16'hFFFF,  1'b0, NO_RES},
		'{ROW_ITEM, KIND_POLL,  4'd0,  16'd1,    16'd0,     1'b1, REPORT_MAX},
		'{ROW_ITEM, KIND_TICK,  4'd0,  16'd1500, 16'd0,     1'b0, NO_RES},
		'{ROW_ITEM, KIND_POLL,  4'd0,  16'd1,    16'd0,     1'b0, NO_RES},
		'{ROW_CFG,  KIND_TICK,  4'd0,  16'd0,    16'd0,     1'b0, NO_RES},
		'{ROW_ITEM, KIND_START, 4'd10, 16'd1,    16'd0,     1'b0, NO_RES},
		'{ROW_ITEM, KIND_STOP,  4'd10, 16'd1,    16'd0,     1'b0, NO_RES},
		'{ROW_ITEM, KIND_POLL,  4'd0,  16'd1,    16'd0,     1'b1, REPORT_OFF}
	};

	// dut signals: inputs known from time zero, outputs as the dut drives them
	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                push         = 1'b0;
	logic [KIND_W-1:0]   kind         = KIND_TICK;
	logic [TI_W-1:0]     timer_index  = '0;
	logic                pop          = 1'b0;
	logic                psel         = 1'b0;
	logic                penable      = 1'b0;
	logic                pwrite       = 1'b0;
	logic [ADDR_W-1:0]   paddr        = '0;
	logic [DATA_W-1:0]   pwdata       = '0;
	logic                full;
	logic                empty;
	logic [1:0]          result_kind;
	logic [PERIOD_W-1:0] seconds_left;
	logic [TIME_W-1:0]   elapsed_ms;
	logic [ENTRY_W-1:0]  entry_index;
	logic [TIME_W-1:0]   total_ms;
	logic [TIME_W-1:0]   event_count;
	logic                last;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	// local copy of the bank state and the period register
	logic [PERIOD_W-1:0] period_s         = '0;
	logic [TIME_W-1:0]   bank_ms          = '0;
	logic [TIME_W-1:0]   last_summary_ms  = '0;
	logic [TIME_W-1:0]   start_stamp [NT] = '{default: '0};
	logic [TIME_W-1:0]   acc_ms [NT]      = '{default: '0};
	logic [TIME_W-1:0]   stop_cnt [NT]    = '{default: '0};
	logic                any_started      = 1'b0;

	result_t expected_results [$];

	int mismatches    = 0;
	int cycles        = 0;
	int items_in      = 0;
	int results_out   = 0;
	int summaries_out = 0;
	int burst_left    = 0;

	interval_profiling_counter_bank_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.kind         (kind),
		.timer_index  (timer_index),
		.empty        (empty),
		.pop          (pop),
		.result_kind  (result_kind),
		.seconds_left (seconds_left),
		.elapsed_ms   (elapsed_ms),
		.entry_index  (entry_index),
		.total_ms     (total_ms),
		.event_count  (event_count),
		.last         (last),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// update the local bank on one accepted item and queue the results it causes
	task automatic predict_bank_results(input logic [KIND_W-1:0] k, input logic [TI_W-1:0] ti);
		logic [TIME_W-1:0] since;
		logic [TIME_W-1:0] window_ms;
		result_t           r;
		r = '0;
		case (k)
			KIND_TICK: begin
				bank_ms = bank_ms + 32'd1;
			end
			KIND_START: begin
				if (period_s != '0) begin
					start_stamp[ti] = bank_ms;
					any_started     = 1'b1;
				end
			end
			KIND_STOP: begin
				if (period_s != '0) begin
					acc_ms[ti]   = acc_ms[ti] + (bank_ms - start_stamp[ti]);
					stop_cnt[ti] = stop_cnt[ti] + 32'd1;
				end
			end
			default: begin
				r.fin = 1'b1;
				since     = bank_ms - last_summary_ms;
				window_ms = 32'(period_s) * 32'd1000;
				if (period_s == '0) begin
					// disabled: a single report of zero
					expected_results.push_back(r);
				end else if (since < window_ms) begin
					r.secs = period_s - 16'(since / 32'd1000);
					expected_results.push_back(r);
				end else begin
					// period over: header, then every timer if any was ever started
					r.rkind = RES_HEADER;
					r.ems   = since;
					r.fin   = !any_started;
					expected_results.push_back(r);
					if (any_started) begin
						for (int i = 0; i < NT; i++) begin
							r       = '0;
							r.rkind = RES_ENTRY;
							r.eidx  = ENTRY_W'(i);
							r.tot   = acc_ms[i];
							r.cnt   = stop_cnt[i];
							r.fin   = (i == NT - 1);
							expected_results.push_back(r);
							acc_ms[i]   = '0;
							stop_cnt[i] = '0;
						end
					end
					last_summary_ms = bank_ms;
				end
			end
		endcase
	endtask

	// called and returns at a falling edge; push stays high into the next call
	task automatic send_item(input logic [KIND_W-1:0] k, input logic [TI_W-1:0] ti,
			input logic typed = 1'b0, input result_t want = '0);
		if (burst_left == 0) begin
			// gap between bursts, sometimes a long burst with no gaps at all
			push <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 24);
		end
		burst_left  = burst_left - 1;
		push        <= 1'b1;
		kind        <= k;
		timer_index <= ti;
		@(posedge clk);
		while (full) @(posedge clk);
		items_in = items_in + 1;
		predict_bank_results(k, ti);
		// rows with a hand-written result replace the single prediction
		if (typed) expected_results[expected_results.size() - 1] = want;
		@(negedge clk);
	endtask

	// sender goes quiet until every result has arrived and the back end has settled
	task automatic drain_results();
		push <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		@(negedge clk);
	endtask

	// period write followed by a read-back, only while the bank is idle
	task automatic write_period(input logic [PERIOD_W-1:0] value);
		drain_results();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_PERIOD, 2'b00};
		pwdata  <= DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		period_s = value;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== DATA_W'(value)) begin
			$error("report_period_s read-back: expected 0x%0h, got 0x%0h", value, prdata);
			mismatches = mismatches + 1;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches = mismatches + 1;
		end
	endfunction

	// result side: every transfer is matched against the oldest expectation
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && pop && !empty) begin
			results_out = results_out + 1;
			if (result_kind == RES_HEADER) summaries_out = summaries_out + 1;
			if (expected_results.size() == 0) begin
				$error("result transfer with nothing expected (kind %0d)", result_kind);
				mismatches = mismatches + 1;
			end else begin
				exp_r = expected_results.pop_front();
				check_field("result_kind",  32'(exp_r.rkind), 32'(result_kind));
				check_field("seconds_left", 32'(exp_r.secs),  32'(seconds_left));
				check_field("elapsed_ms",   exp_r.ems,        elapsed_ms);
				check_field("entry_index",  32'(exp_r.eidx),  32'(entry_index));
				check_field("total_ms",     exp_r.tot,        total_ms);
				check_field("event_count",  exp_r.cnt,        event_count);
				check_field("last",         32'(exp_r.fin),   32'(last));
			end
		end
	end

	// receiver stalls on a rotating pattern, redrawn when the cycle counter is a multiple of 64;
	// a third of the patterns never stall
	always @(negedge clk) begin
		logic [15:0] pat;
		if (cycles % 64 == 0 || $isunknown(pat)) begin
			pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
		end else begin
			pat = {pat[14:0], pat[15]};
		end
		pop <= pat[0];
	end

	initial begin
		row_t              row;
		logic [TI_W-1:0]   t;
		logic [KIND_W-1:0] nk;
		int                sent;
		int                choice;
		logic              paused;
		paused = 1'b0;

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part: disabled bank, first report, header with no timer started,
		// stop without a start, summary with entries, widest period, disable again
		for (int r = 0; r < $size(DIRECTED); r++) begin
			row = DIRECTED[r];
			if (row.op == ROW_CFG) begin
				write_period(row.cfg);
			end else begin
				repeat (row.reps) send_item(row.kind, row.idx, row.typed, row.want);
			end
		end

		// random part: one period per phase, the extremes among them
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0:       write_period(16'd1);
				1:       write_period(16'($urandom_range(2, 3)));
				2:       write_period(16'd0);
				3:       write_period(16'hFFFF);
				4:       write_period(16'($urandom_range(4, 65534)));
				default: write_period(16'd1);
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				choice = $urandom_range(0, 99);
				if (choice < 50) begin
					// well-formed interval: start, some ticks, stop on the same timer
					t = TI_W'($urandom_range(0, NT - 1));
					send_item(KIND_START, t);
					repeat ($urandom_range(0, 300)) send_item(KIND_TICK, TI_W'($urandom));
					send_item(KIND_STOP, t);
					sent = sent + 2;
				end else if (choice < 70) begin
					send_item(KIND_POLL, TI_W'($urandom));
					sent = sent + 1;
				end else if (choice < 85) begin
					repeat ($urandom_range(1, 900)) send_item(KIND_TICK, TI_W'($urandom));
				end else begin
					// noise: any kind, any index
					nk = KIND_W'($urandom);
					send_item(nk, TI_W'($urandom));
					if (nk != KIND_TICK) sent = sent + 1;
				end
				// hold off once mid-phase until every expected result has come out
				if (ph == 1 && !paused && sent >= PHASE_ITEMS / 2) begin
					drain_results();
					paused = 1'b1;
				end
			end
		end

		drain_results();
		$display("run covered %0d item transfers and %0d result transfers", items_in, results_out);
		$display("%0d summaries emitted over %0d periods, %0d mismatches",
			summaries_out, NUM_PHASES + 3, mismatches);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/ipcb_pkg.sv
hw/rtl/ipcb_front.sv
hw/rtl/ipcb_queue.sv
hw/rtl/ipcb_back.sv
hw/rtl/interval_profiling_counter_bank_unit.sv
hw/rtl/ipcb_checker.sv
sim/tb_interval_profiling_counter_bank_unit.sv
